// ===== design/sotp_pkg.sv =====
// Package: shared types and constants of the slot owner protection table.
`default_nettype none

package sotp_pkg;

    localparam int MAX_SLOTS_DEF  = 4096;
    localparam int SLOT_SHIFT_DEF = 5;
    localparam int UNOWNED_ID_DEF = 255;

    localparam int ACC_W   = 34;
    localparam int SLOTS_W = 13;
    localparam int ID_W    = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [31:0] HIGH_REGION_BASE = 32'hE000_0000;
    localparam logic [31:0] OFFSET_MASK      = 32'h1FFF_FFFF;
    localparam logic [SLOTS_W-1:0] SLOTS_RESET = 13'd4096;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS      = 2'd1;

    typedef enum logic [1:0] {
        REQ_CHECK,
        REQ_STAMP,
        REQ_CLEAR,
        REQ_RELEASE
    } t_req;

    typedef enum logic [2:0] {
        ST_WIPE,
        ST_IDLE,
        ST_CALC0,
        ST_CALC1,
        ST_BOUND,
        ST_SCAN,
        ST_FILL
    } t_state;

endpackage

`default_nettype wire

// ===== design/sotp_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module sotp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/sotp_alu.sv =====
// Shared range adder: sum of two operands less an optional one.
`default_nettype none

module sotp_alu (
    input  wire logic [sotp_pkg::ACC_W-1:0] i_a,
    input  wire logic [sotp_pkg::ACC_W-1:0] i_b,
    input  wire logic                       i_dec,
    output logic      [sotp_pkg::ACC_W-1:0] o_sum
);

    import sotp_pkg::*;

    assign o_sum = i_a + i_b - ACC_W'(i_dec);

endmodule

`default_nettype wire

// ===== design/slot_owner_protection_table.sv =====
// Top level: slot owner protection table with sequencer over an owner RAM.
//
// Input channel i_valid/o_ready carries one request item: type, requester,
// address and length. Output channel o_valid/i_ready returns one item per
// request with the allowed flag. Config writes (i_cfg_we, i_cfg_idx,
// i_cfg_data) take effect at once: index 0 map enable, index 1 slot count.
// After reset the owner RAM is swept to unowned, one slot per cycle, over
// all MAX_SLOTS slots (4096 by default); o_ready stays low meanwhile.
// One item is in flight at a time; o_ready is low until its result is taken.
// A check ends without a scan when the map is disabled, the length is zero,
// the address is high or its range reaches past the slot count; a stamp or
// clear when the map is disabled, the length is zero or it starts past the
// slot count; a release only when the map is disabled. A check reads slots
// through the single RAM read port and stops at a foreign slot; a release
// frees the requester's slots in use; a stamp or clear writes one per cycle.
// With i_ready high, o_ready rises again once the result has been taken.
// A stalled result holds in the output register until i_ready is high.
`default_nettype none

module slot_owner_protection_table #(
    parameter int MAX_SLOTS  = sotp_pkg::MAX_SLOTS_DEF,
    parameter int SLOT_SHIFT = sotp_pkg::SLOT_SHIFT_DEF,
    parameter int UNOWNED_ID = sotp_pkg::UNOWNED_ID_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [1:0]                     i_req_type,
    input  wire logic [sotp_pkg::ID_W-1:0]      i_requester_id,
    input  wire logic [31:0]                    i_address,
    input  wire logic [31:0]                    i_length,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic                                o_allowed,
    input  wire logic                           i_cfg_we,
    input  wire logic [sotp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [sotp_pkg::SLOTS_W-1:0]   i_cfg_data
);

    import sotp_pkg::*;

    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam logic [ID_W-1:0]  UNOWNED = ID_W'(UNOWNED_ID);
    localparam logic [CW-1:0]    LAST_SLOT = CW'(MAX_SLOTS - 1);
    localparam logic [ACC_W-1:0] ROUND_UP = (ACC_W'(1) << SLOT_SHIFT) - ACC_W'(1);

    t_state r_state, n_state;
    t_req   r_type;
    logic [ID_W-1:0]  r_id;
    logic [31:0]      r_addr, r_len;
    logic [ACC_W-1:0] r_acc, n_acc;
    logic [CW-1:0]    r_s, n_s, r_end, n_end;
    logic             r_chk_v, n_chk_v;
    logic [AW-1:0]    r_chk_addr, n_chk_addr;
    logic             r_out_valid, n_out_valid, r_ok, n_ok;
    logic             r_map_en;
    logic [SLOTS_W-1:0] r_slots;

    logic [ACC_W-1:0] alu_a, alu_b, alu_sum;
    logic             alu_dec;
    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [ID_W-1:0]  ram_wdata, ram_rdata;

    logic [CW-1:0]    lim;
    logic [ACC_W-1:0] lim34, hi34, lo_chk, lo_fill, end_c;
    logic [31:0]      off;
    logic             early_chk, early_fill, deny, issue, finish, fin_ok, accept;

    sotp_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_dec (alu_dec),
        .o_sum (alu_sum)
    );

    sotp_ram #(
        .WIDTH (ID_W),
        .DEPTH (MAX_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign accept    = i_valid && o_ready;
    assign o_valid   = r_out_valid;
    assign o_allowed = r_ok;

    // range bookkeeping
    always_comb begin
        lim        = (32'(r_slots) > 32'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : CW'(r_slots);
        lim34      = ACC_W'(lim);
        off        = r_addr & OFFSET_MASK;
        early_chk  = !r_map_en || (r_len == 32'd0) || (r_addr >= HIGH_REGION_BASE);
        early_fill = !r_map_en || (r_len == 32'd0);
        hi34       = r_acc >> SLOT_SHIFT;
        lo_chk     = ACC_W'(off) >> SLOT_SHIFT;
        lo_fill    = ACC_W'(r_addr) >> SLOT_SHIFT;
        end_c      = (r_acc > lim34) ? lim34 : r_acc;
        deny       = (r_state == ST_SCAN) && r_chk_v && (r_type == REQ_CHECK) &&
                     (ram_rdata != r_id) && (ram_rdata != UNOWNED);
        issue      = (r_state == ST_SCAN) && (r_s < r_end) && !deny;
    end

    // completion status
    always_comb begin
        finish = 1'b0;
        fin_ok = 1'b1;
        case (r_state)
            ST_CALC0: begin
                case (r_type)
                    REQ_CHECK:   finish = early_chk;
                    REQ_RELEASE: finish = !r_map_en;
                    default:     finish = early_fill;
                endcase
            end
            ST_BOUND: begin
                if (r_type == REQ_CHECK) begin
                    finish = (hi34 >= lim34);
                end else begin
                    finish = (lo_fill >= end_c);
                end
            end
            ST_SCAN: begin
                finish = deny || ((r_s >= r_end) && !r_chk_v);
                fin_ok = !deny;
            end
            ST_FILL: finish = (r_s == r_end - CW'(1));
            default: finish = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_WIPE:  if (r_s == LAST_SLOT) n_state = ST_IDLE;
            ST_IDLE:  if (accept) n_state = ST_CALC0;
            ST_CALC0: begin
                if (finish) begin
                    n_state = ST_IDLE;
                end else if (r_type == REQ_CHECK) begin
                    n_state = ST_BOUND;
                end else if (r_type == REQ_RELEASE) begin
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_CALC1;
                end
            end
            ST_CALC1: n_state = ST_BOUND;
            ST_BOUND: begin
                if (finish) begin
                    n_state = ST_IDLE;
                end else if (r_type == REQ_CHECK) begin
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_FILL;
                end
            end
            ST_SCAN, ST_FILL: if (finish) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs: handshake, adder operands, RAM ports
    always_comb begin
        o_ready   = (r_state == ST_IDLE) && !r_out_valid;
        alu_a     = ACC_W'(r_len);
        alu_b     = ROUND_UP;
        alu_dec   = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_s[AW-1:0];
        ram_wdata = UNOWNED;
        ram_re    = issue;
        ram_raddr = r_s[AW-1:0];
        case (r_state)
            ST_WIPE: ram_we = 1'b1;
            ST_CALC0: begin
                if (r_type == REQ_CHECK) begin
                    alu_a   = ACC_W'(off);
                    alu_b   = ACC_W'(r_len);
                    alu_dec = 1'b1;
                end
            end
            ST_CALC1: begin
                alu_a = lo_fill;
                alu_b = r_acc >> SLOT_SHIFT;
            end
            ST_SCAN: begin
                ram_we    = r_chk_v && (r_type == REQ_RELEASE) && (ram_rdata == r_id);
                ram_waddr = r_chk_addr;
            end
            ST_FILL: begin
                ram_we    = 1'b1;
                ram_wdata = (r_type == REQ_STAMP) ? r_id : UNOWNED;
            end
            default: ram_we = 1'b0;
        endcase
    end

    // datapath next values
    always_comb begin
        n_acc       = r_acc;
        n_s         = r_s;
        n_end       = r_end;
        n_chk_v     = issue;
        n_chk_addr  = r_s[AW-1:0];
        n_ok        = finish ? fin_ok : r_ok;
        n_out_valid = finish || (r_out_valid && !i_ready);
        case (r_state)
            ST_WIPE: n_s = r_s + CW'(1);
            ST_CALC0: begin
                n_acc = alu_sum;
                n_s   = '0;
                n_end = lim;
            end
            ST_CALC1: n_acc = alu_sum;
            ST_BOUND: begin
                if (r_type == REQ_CHECK) begin
                    n_s   = CW'(lo_chk);
                    n_end = CW'(hi34) + CW'(1);
                end else begin
                    n_s   = CW'(lo_fill);
                    n_end = CW'(end_c);
                end
            end
            ST_SCAN: if (issue) n_s = r_s + CW'(1);
            ST_FILL: n_s = r_s + CW'(1);
            default: n_s = r_s;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_WIPE;
            r_s         <= '0;
            r_chk_v     <= 1'b0;
            r_out_valid <= 1'b0;
            r_map_en    <= 1'b0;
            r_slots     <= SLOTS_RESET;
        end else begin
            r_state     <= n_state;
            r_s         <= n_s;
            r_chk_v     <= n_chk_v;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_MAP_ENABLE) begin
                    r_map_en <= i_cfg_data[0];
                end else if (i_cfg_idx == CFG_SLOTS) begin
                    r_slots <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc      <= n_acc;
        r_end      <= n_end;
        r_chk_addr <= n_chk_addr;
        r_ok       <= n_ok;
        if (accept) begin
            r_type <= t_req'(i_req_type);
            r_id   <= i_requester_id;
            r_addr <= i_address;
            r_len  <= i_length;
        end
    end

    a_reset_wipes: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_state == ST_WIPE) && (r_s == '0))
        else $error("reset does not start the owner sweep");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_CALC0 || r_state == ST_BOUND) |-> !ram_we)
        else $error("owner RAM written outside a sweep");

    a_scan_write_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && ram_we) |-> r_chk_v && (r_type == REQ_RELEASE))
        else $error("release write without read data");

    a_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FILL) |-> (r_s < r_end) && (r_end <= lim))
        else $error("fill slot outside clamped range");

    a_result_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |-> !r_out_valid)
        else $error("new result while previous one pending");

endmodule

`default_nettype wire
